>>> rtl/mknn_pkg.sv
// ----------------------------------------------------------------------------
// mknn_pkg
// Types and constants shared by the masked k-nearest-neighbor classifier.
// ----------------------------------------------------------------------------
package mknn_pkg;

  localparam int FEAT_W  = 16;
  localparam int LABEL_W = 2;
  localparam int K_W     = 4;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic REG_K    = 1'b0;
  localparam logic REG_MASK = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [FEAT_W-1:0] feature_value;
    logic [LABEL_W-1:0]       class_label;
    logic                     last_feature;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] predicted_label;
    logic               correct;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] tested;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_VOTE,
    ST_PICK,
    ST_DONE
  } state_t;

endpackage

>>> rtl/mknn_cell.sv
// ----------------------------------------------------------------------------
// mknn_cell
// One feature cell: holds one column of the training store and one test
// feature, and adds its masked squared difference to the passing sum.
// ----------------------------------------------------------------------------
module mknn_cell #(
  parameter int TRAIN_DEPTH = 1024,
  parameter int ROW_W       = 10,
  parameter int DIST_W      = 37
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [ROW_W-1:0]                wr_row,
  input  logic [mknn_pkg::FEAT_W-1:0]     wr_data,
  input  logic                            test_en,
  input  logic                            mask_bit,
  input  logic                            up_valid,
  input  logic [ROW_W-1:0]                up_row,
  input  logic [mknn_pkg::LABEL_W-1:0]    up_label,
  input  logic [DIST_W-1:0]               up_sum,
  output logic                            dn_valid,
  output logic [ROW_W-1:0]                dn_row,
  output logic [mknn_pkg::LABEL_W-1:0]    dn_label,
  output logic [DIST_W-1:0]               dn_sum
);
  import mknn_pkg::*;

  logic [FEAT_W-1:0]  mem [TRAIN_DEPTH];
  logic [FEAT_W-1:0]  test_feat;
  logic [FEAT_W-1:0]  rd;
  logic               v1, v2;
  logic [ROW_W-1:0]   row1, row2;
  logic [LABEL_W-1:0] lab1, lab2;
  logic [DIST_W-1:0]  sum1, sum2;
  logic [2*FEAT_W-1:0] sq;
  logic [FEAT_W:0]    diff;
  logic [FEAT_W-1:0]  mag;

  always_comb begin
    diff = {test_feat[FEAT_W-1], test_feat} - {rd[FEAT_W-1], rd};
    mag  = diff[FEAT_W] ? FEAT_W'(-diff) : diff[FEAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (test_en) begin
      test_feat <= wr_data;
    end
    rd   <= mem[up_row];
    row1 <= up_row;
    lab1 <= up_label;
    sum1 <= up_sum;
    sq   <= mask_bit ? mag * mag : '0;
    row2 <= row1;
    lab2 <= lab1;
    sum2 <= sum1;
    dn_sum   <= sum2 + DIST_W'(sq);
    dn_row   <= row2;
    dn_label <= lab2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      v1       <= up_valid;
      v2       <= v1;
      dn_valid <= v2;
    end
  end

endmodule

>>> rtl/mknn_sort.sv
// ----------------------------------------------------------------------------
// mknn_sort
// Sorted row of neighbor slots; each slot keeps its entry, takes the new
// key, or takes its upper neighbor's entry on every insertion.
// ----------------------------------------------------------------------------
module mknn_sort #(
  parameter int K_MAX  = 15,
  parameter int DIST_W = 37
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clr,
  input  logic                                ins,
  input  logic [DIST_W-1:0]                   ins_dist,
  input  logic [mknn_pkg::LABEL_W-1:0]        ins_label,
  output logic [K_MAX-1:0]                    slot_valid,
  output logic [K_MAX*mknn_pkg::LABEL_W-1:0]  slot_label
);
  import mknn_pkg::*;

  localparam int KEY_W = DIST_W + LABEL_W;

  logic [KEY_W-1:0] key [K_MAX];
  logic [KEY_W-1:0] new_key;
  logic [K_MAX-1:0] less;

  assign new_key = {ins_dist, ins_label};

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      less[i] = !slot_valid[i] || (new_key < key[i]);
      slot_label[i*LABEL_W +: LABEL_W] = key[i][LABEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      slot_valid <= '0;
    end else if (ins) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (less[i]) begin
          if (i > 0 && less[i-1]) begin
            slot_valid[i] <= slot_valid[i-1];
          end else begin
            slot_valid[i] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (less[i]) begin
          if (i > 0 && less[i-1]) begin
            key[i] <= key[i-1];
          end else begin
            key[i] <= new_key;
          end
        end
      end
    end
  end

endmodule

>>> rtl/masked_knn_classifier.sv
// ----------------------------------------------------------------------------
// masked_knn_classifier
// k-nearest-neighbor classifier with a feature mask and a majority vote.
// ----------------------------------------------------------------------------
// Each input beat carries one feature. Beats with operation load fill the
// training store, one row per vector; beats with operation test fill the
// test vector. The beat that ends a test vector starts a classification,
// and one output beat follows with the predicted class, the match flag and
// the hit and test counts. No other input beat yields an output beat.
// Load beats and non-final test beats are taken one per cycle while idle.
// During a classification, with N stored rows, F features, K = K_MAX and
// C = NUM_CLASSES, the N rows stream through the chain of feature cells
// one per cycle, each cell adding one masked squared difference, then the
// K sorted neighbor slots are counted one per cycle and the C classes
// compared one per cycle. in_stall is high throughout the classification.
// A finished result waits in the output register while out_stall is high;
// the next vector may be loaded meanwhile. Reset empties the store, clears
// the counters, and sets k to one and all mask bits to one.
// ----------------------------------------------------------------------------
module masked_knn_classifier #(
  parameter int NUM_FEATURES = 16,
  parameter int TRAIN_DEPTH  = 1024,
  parameter int K_MAX        = 15,
  parameter int NUM_CLASSES  = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mknn_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mknn_pkg::out_t             out_data,
  input  logic                       cfg_en,
  input  logic                       cfg_index,
  input  logic [mknn_pkg::CFG_W-1:0] cfg_data
);
  import mknn_pkg::*;

  localparam int ROW_W   = TRAIN_DEPTH > 1 ? $clog2(TRAIN_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TRAIN_DEPTH + 1);
  localparam int POS_W   = $clog2(NUM_FEATURES + 1);
  localparam int DIST_W  = 2 * FEAT_W + $clog2(NUM_FEATURES + 1);
  localparam int KE_W    = $clog2(K_MAX + 1);
  localparam int CLS_W   = $clog2(NUM_CLASSES + 1);
  localparam int CW      = CNT_W > 7 ? CNT_W : 7;
  localparam int DRAIN   = 3 * NUM_FEATURES + 2;
  localparam int DR_W    = $clog2(DRAIN + 1);

  state_t state, state_next;

  logic [K_W-1:0]      k_reg;
  logic [MASK_W-1:0]   mask_reg;
  logic [CNT_W-1:0]    count;
  logic [POS_W-1:0]    pos;
  logic [LABEL_W-1:0]  labels [TRAIN_DEPTH];
  logic [LABEL_W-1:0]  true_lab;
  logic [CNT_W-1:0]    walk_row;
  logic [DR_W-1:0]     drain_cnt;
  logic [KE_W-1:0]     idx;
  logic [CLS_W-1:0]    cls;
  logic [KE_W-1:0]     votes [NUM_CLASSES];
  logic [KE_W-1:0]     top;
  logic [CLS_W-1:0]    win;
  logic [COUNT_W-1:0]  hit_count, test_count;
  logic                issue_v;
  logic [ROW_W-1:0]    issue_row;
  logic [LABEL_W-1:0]  issue_lab;
  logic                in_acc, store_ok, walk_more, sort_clr;
  logic [CW-1:0]       k_eff;
  logic [K_MAX-1:0]    slot_valid;
  logic [K_MAX*LABEL_W-1:0] slot_label;
  logic                sel_valid;
  logic [LABEL_W-1:0]  sel_label;
  logic [KE_W-1:0]     sel_votes;
  logic [LABEL_W-1:0]  pred;

  logic                c_valid [NUM_FEATURES+1];
  logic [ROW_W-1:0]    c_row   [NUM_FEATURES+1];
  logic [LABEL_W-1:0]  c_label [NUM_FEATURES+1];
  logic [DIST_W-1:0]   c_sum   [NUM_FEATURES+1];

  assign in_acc    = in_valid && !in_stall;
  assign store_ok  = count < CNT_W'(TRAIN_DEPTH);
  assign walk_more = walk_row < count;

  always_comb begin
    k_eff = CW'(k_reg);
    if (k_eff > CW'(K_MAX)) begin
      k_eff = CW'(K_MAX);
    end
    if (k_eff > CW'(count)) begin
      k_eff = CW'(count);
    end
  end

  always_comb begin
    sel_valid = 1'b0;
    sel_label = '0;
    for (int e = 0; e < K_MAX; e++) begin
      if (idx == KE_W'(e)) begin
        sel_valid = slot_valid[e];
        sel_label = slot_label[e*LABEL_W +: LABEL_W];
      end
    end
    sel_votes = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls == CLS_W'(c)) begin
        sel_votes = votes[c];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_data.last_feature && in_data.operation == OP_TEST) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = ST_VOTE;
        end
      end
      ST_VOTE: begin
        if (idx == KE_W'(K_MAX - 1)) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (cls == CLS_W'(NUM_CLASSES - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    sort_clr = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        sort_clr = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign pred = LABEL_W'(win);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k_reg      <= K_W'(1);
      mask_reg   <= '1;
      count      <= '0;
      pos        <= '0;
      hit_count  <= '0;
      test_count <= '0;
      out_valid  <= 1'b0;
      issue_v    <= 1'b0;
    end else begin
      state   <= state_next;
      issue_v <= (state == ST_WALK) && walk_more;
      if (cfg_en) begin
        if (cfg_index == REG_K) begin
          k_reg <= cfg_data[K_W-1:0];
        end else begin
          mask_reg <= cfg_data[MASK_W-1:0];
        end
      end
      if (in_acc) begin
        if (in_data.last_feature) begin
          pos <= '0;
          if (in_data.operation == OP_LOAD && store_ok) begin
            count <= count + 1'b1;
          end
        end else if (pos < POS_W'(NUM_FEATURES)) begin
          pos <= pos + 1'b1;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        if (pred == true_lab && hit_count != '1) begin
          hit_count <= hit_count + 1'b1;
        end
        if (test_count != '1) begin
          test_count <= test_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last_feature && in_data.operation == OP_LOAD && store_ok) begin
      labels[count[ROW_W-1:0]] <= in_data.class_label;
    end
    if (in_acc && in_data.last_feature) begin
      true_lab <= in_data.class_label;
    end
    issue_lab <= labels[walk_row[ROW_W-1:0]];
    issue_row <= walk_row[ROW_W-1:0];
    if (state == ST_IDLE) begin
      walk_row  <= '0;
      drain_cnt <= DR_W'(DRAIN);
      idx       <= '0;
      cls       <= '0;
      top       <= '0;
      win       <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        votes[c] <= '0;
      end
    end
    if (state == ST_WALK && walk_more) begin
      walk_row <= walk_row + 1'b1;
    end
    if (state == ST_DRAIN) begin
      drain_cnt <= drain_cnt - 1'b1;
    end
    if (state == ST_VOTE) begin
      idx <= idx + 1'b1;
      if (CW'(idx) < k_eff && sel_valid) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (CLS_W'(sel_label) == CLS_W'(c) && c < (1 << LABEL_W)) begin
            votes[c] <= votes[c] + 1'b1;
          end
        end
      end
    end
    if (state == ST_PICK) begin
      cls <= cls + 1'b1;
      if (sel_votes > top) begin
        top <= sel_votes;
        win <= cls;
      end
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_data.predicted_label <= pred;
      out_data.correct         <= pred == true_lab;
      out_data.hits            <= (pred == true_lab && hit_count != '1)
                                  ? hit_count + 1'b1 : hit_count;
      out_data.tested          <= (test_count != '1) ? test_count + 1'b1 : test_count;
    end
  end

  assign c_valid[0] = issue_v;
  assign c_row[0]   = issue_row;
  assign c_label[0] = issue_lab;
  assign c_sum[0]   = '0;

  for (genvar f = 0; f < NUM_FEATURES; f++) begin : g_cell
    logic mbit;
    logic wr_en, test_en;
    if (f < MASK_W) begin : g_m
      assign mbit = mask_reg[f];
    end else begin : g_nm
      assign mbit = 1'b0;
    end
    assign wr_en   = in_acc && in_data.operation == OP_LOAD && store_ok
                     && pos == POS_W'(f);
    assign test_en = in_acc && in_data.operation == OP_TEST && pos == POS_W'(f);

    mknn_cell #(
      .TRAIN_DEPTH(TRAIN_DEPTH),
      .ROW_W      (ROW_W),
      .DIST_W     (DIST_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en),
      .wr_row  (count[ROW_W-1:0]),
      .wr_data (in_data.feature_value),
      .test_en (test_en),
      .mask_bit(mbit),
      .up_valid(c_valid[f]),
      .up_row  (c_row[f]),
      .up_label(c_label[f]),
      .up_sum  (c_sum[f]),
      .dn_valid(c_valid[f+1]),
      .dn_row  (c_row[f+1]),
      .dn_label(c_label[f+1]),
      .dn_sum  (c_sum[f+1])
    );
  end

  mknn_sort #(
    .K_MAX (K_MAX),
    .DIST_W(DIST_W)
  ) u_sort (
    .clk       (clk),
    .rst       (rst),
    .clr       (sort_clr),
    .ins       (c_valid[NUM_FEATURES]),
    .ins_dist  (c_sum[NUM_FEATURES]),
    .ins_label (c_label[NUM_FEATURES]),
    .slot_valid(slot_valid),
    .slot_label(slot_label)
  );

endmodule

>>> rtl/mknn_check.sv
// ----------------------------------------------------------------------------
// mknn_check
// Port-level checks for the masked k-nearest-neighbor classifier.
// ----------------------------------------------------------------------------
module mknn_check (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input mknn_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input mknn_pkg::out_t out_data
);
  import mknn_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.operation == OP_TEST && in_data.last_feature
    |=> in_stall)
    else $error("input taken during classification");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hits <= out_data.tested)
    else $error("hit count above test count");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat right after reset");

endmodule

bind masked_knn_classifier mknn_check u_check (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked k-nearest-neighbor classifier testbench
// Loads training vectors and streams test vectors under random pacing and
// output stalls, predicts each classification in a scoreboard model and
// compares every output beat field by field.
// ----------------------------------------------------------------------------
import mknn_pkg::*;

class knn_scoreboard;
  logic [15:0] train_feat [1024][16];
  logic [1:0]  train_lab [1024];
  int          train_cnt;
  logic [15:0] test_vec [16];
  int          pos;
  int          hit_cnt;
  int          test_cnt;
  int          k_cfg;
  logic [15:0] mask_cfg;
  out_t        pending [$];
  int          errors;

  function void clear();
    train_cnt = 0;
    pos = 0;
    hit_cnt = 0;
    test_cnt = 0;
    k_cfg = 1;
    mask_cfg = 16'hFFFF;
    pending.delete();
    errors = 0;
  endfunction

  function logic [1:0] vote();
    longint unsigned nbr_dist [15];
    int lab [15];
    int votes [4];
    int held, k, i, win;
    longint unsigned d;
    longint signed df;
    held = 0;
    k = k_cfg;
    if (k > train_cnt) k = train_cnt;
    if (k == 0) return 2'd0;
    for (int r = 0; r < train_cnt; r++) begin
      d = 0;
      for (int f = 0; f < 16; f++) begin
        if (mask_cfg[f]) begin
          df = longint'($signed(test_vec[f])) - longint'($signed(train_feat[r][f]));
          d += df * df;
        end
      end
      if (held < k) begin
        i = held;
        held++;
      end else if (d < nbr_dist[k-1] || (d == nbr_dist[k-1] && train_lab[r] < lab[k-1])) begin
        i = k - 1;
      end else begin
        continue;
      end
      while (i > 0 && (d < nbr_dist[i-1] ||
                       (d == nbr_dist[i-1] && train_lab[r] < lab[i-1]))) begin
        nbr_dist[i] = nbr_dist[i-1];
        lab[i] = lab[i-1];
        i--;
      end
      nbr_dist[i] = d;
      lab[i] = train_lab[r];
    end
    votes = '{0, 0, 0, 0};
    for (int r = 0; r < held; r++) votes[lab[r]]++;
    win = 0;
    for (int c = 1; c < 4; c++) if (votes[c] > votes[win]) win = c;
    return win[1:0];
  endfunction

  function void note_beat(in_t b);
    out_t e;
    if (pos < 16) begin
      if (b.operation == OP_LOAD) begin
        if (train_cnt < 1024) train_feat[train_cnt][pos] = b.feature_value;
      end else begin
        test_vec[pos] = b.feature_value;
      end
      pos++;
    end
    if (!b.last_feature) return;
    pos = 0;
    if (b.operation == OP_LOAD) begin
      if (train_cnt < 1024) begin
        train_lab[train_cnt] = b.class_label;
        train_cnt++;
      end
      return;
    end
    e.predicted_label = vote();
    e.correct = (e.predicted_label == b.class_label);
    if (e.correct && hit_cnt < 65535) hit_cnt++;
    if (test_cnt < 65535) test_cnt++;
    e.hits = hit_cnt[15:0];
    e.tested = test_cnt[15:0];
    pending = {pending, e};
  endfunction

  function void check_result(out_t a);
    out_t e;
    if (pending.size() == 0) begin
      $error("unexpected output beat %p", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.predicted_label !== e.predicted_label) begin
      $error("predicted_label expected %0d actual %0d", e.predicted_label, a.predicted_label);
      errors++;
    end
    if (a.correct !== e.correct) begin
      $error("correct expected %0d actual %0d", e.correct, a.correct);
      errors++;
    end
    if (a.hits !== e.hits) begin
      $error("hits expected %0d actual %0d", e.hits, a.hits);
      errors++;
    end
    if (a.tested !== e.tested) begin
      $error("tested expected %0d actual %0d", e.tested, a.tested);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_en = 1'b0;
  logic cfg_index = REG_K;
  logic [CFG_W-1:0] cfg_data = '0;

  knn_scoreboard sb;
  int  cycles = 0;
  int  hold_off = 0;
  bit  hold_req = 1'b0;
  int  gap_left = 0;
  int  burst_left = 0;
  bit  written [16];

  masked_knn_classifier dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stall pattern with one long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_off <= 3000;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (cycles % 2000 < 500) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(3) == 0);
    end
  end

  task automatic send_beat(logic op, logic [15:0] v, logic [1:0] lab, logic last);
    int p;
    if (burst_left == 0) begin
      gap_left = ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
      burst_left = $urandom_range(1, 30);
    end
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
      gap_left--;
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{operation: op, feature_value: v, class_label: lab, last_feature: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = sb.pos;
    sb.note_beat('{operation: op, feature_value: v, class_label: lab, last_feature: last});
    if (op == OP_TEST && p < 16) written[p] = 1'b1;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_feat(bit near);
    if (near) return 16'($urandom_range(0, 2047)) - 16'd1024;
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(logic op, int len, logic [1:0] lab, bit near);
    for (int i = 0; i < len; i++) begin
      if (op == OP_TEST && i == len - 1) begin
        // A test vector may only end once every position it reads holds data.
        for (int p = 0; p < 16; p++) if (!written[p] && p >= i) begin
          send_beat(op, rand_feat(near), lab, 1'b0);
          written[p] = 1'b1;
        end
      end
      send_beat(op, rand_feat(near), lab, i == len - 1);
    end
  endtask

  task automatic drain_and_write(logic idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_en <= 1'b0;
    if (idx == REG_K) sb.k_cfg = val[3:0];
    else sb.mask_cfg = val;
  endtask

  task automatic random_vector();
    logic op;
    int len;
    bit near;
    op = ($urandom_range(3) == 0) ? OP_LOAD : OP_TEST;
    near = $urandom_range(1);
    case ($urandom_range(9))
      0: len = $urandom_range(17, 20);
      1: len = $urandom_range(1, 15);
      default: len = 16;
    endcase
    // Training rows must fill every position they are later read at.
    if (op == OP_LOAD && len < 16) len = 16;
    if (op == OP_TEST && $urandom_range(15) == 0) begin
      send_beat(~op, rand_feat(near), 2'($urandom), 1'b0);
      len--;
      if (len < 1) len = 1;
    end
    send_vector(op, len, 2'($urandom), near);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty store: nobody votes.
    send_vector(OP_TEST, 16, 2'd0, 1'b0);
    send_vector(OP_TEST, 16, 2'd1, 1'b0);
    for (int i = 0; i < 6; i++) send_vector(OP_LOAD, 16, 2'(i), 1'b0);
    send_vector(OP_LOAD, 18, 2'd3, 1'b0);
    send_vector(OP_TEST, 19, 2'd2, 1'b1);
    send_vector(OP_TEST, 4, 2'd1, 1'b1);
    drain_and_write(REG_K, 16'd15);
    drain_and_write(REG_MASK, 16'h0000);
    send_vector(OP_TEST, 16, 2'd0, 1'b1);
    send_vector(OP_TEST, 16, 2'd3, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      drain_and_write(REG_K, (phase == 0) ? 16'd1 : 16'($urandom_range(1, 15)));
      drain_and_write(REG_MASK, (phase == 1) ? 16'hFFFF : (phase == 2) ? 16'h0001 :
                      16'($urandom));
      if (phase == 3) hold_req = 1'b1;
      for (int v = 0; v < 14; v++) random_vector();
    end
    drain_and_write(REG_K, 16'd15);
    drain_and_write(REG_MASK, 16'hFFFF);

    while (sb.pending.size() != 0 && cycles < 3900000) @(negedge clk);
    repeat (1200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
